// File: src/h84sd_pkg.sv
// Shared types, constants and code table for the Hamming (8,4) soft decoder.
// No dependencies.
`default_nettype none

package h84sd_pkg;

   localparam int SoftWidth  = 8;
   localparam int NumBits    = 8;
   localparam int NumSymbols = 16;
   localparam int SymWidth   = 4;
   localparam int DistWidth  = 11;  // 8 * 255 = 2040 fits
   localparam int ByteWidth  = 8;

   typedef logic [SoftWidth-1:0]    soft_type;
   typedef soft_type [NumBits-1:0]  soft_vec_type;  // [0] is codeword bit 7
   typedef logic [SymWidth-1:0]     sym_type;
   typedef logic [DistWidth-1:0]    dist_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   function automatic logic [NumBits-1:0] code_word(input sym_type sym);
      logic [NumBits-1:0] word;
      unique case (sym)
         4'd0:  word = 8'h00;
         4'd1:  word = 8'hd2;
         4'd2:  word = 8'h55;
         4'd3:  word = 8'h87;
         4'd4:  word = 8'h99;
         4'd5:  word = 8'h4b;
         4'd6:  word = 8'hcc;
         4'd7:  word = 8'h1e;
         4'd8:  word = 8'he1;
         4'd9:  word = 8'h33;
         4'd10: word = 8'hb4;
         4'd11: word = 8'h66;
         4'd12: word = 8'h78;
         4'd13: word = 8'haa;
         4'd14: word = 8'h2d;
         default: word = 8'hff;
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

// File: src/h84sd_dist.sv
// Soft distance between the held codeword and one candidate from the code table.
// Depends on h84sd_pkg.
`default_nettype none

module h84sd_dist
   import h84sd_pkg::*;
(
   input  wire soft_vec_type rx_soft,
   input  wire sym_type      cand,
   output dist_type          cand_dist
);

   logic [NumBits-1:0] word;
   soft_type           term [NumBits];

   assign word = code_word(cand);

   // cost is 255-soft (the bitwise inverse) where the candidate bit is one
   always_comb begin
      for (int b = 0; b < NumBits; b++) begin
         term[b] = word[NumBits-1-b] ? ~rx_soft[b] : rx_soft[b];
      end
   end

   // balanced adder tree, widths grow one bit per level
   logic [SoftWidth:0]   sum_a [4];
   logic [SoftWidth+1:0] sum_b [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_a[i] = {1'b0, term[2*i]} + {1'b0, term[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         sum_b[i] = {1'b0, sum_a[2*i]} + {1'b0, sum_a[2*i+1]};
      end
   end

   assign cand_dist = {1'b0, sum_b[0]} + {1'b0, sum_b[1]};

endmodule

`default_nettype wire

// File: src/hamming84_soft_decoder_unit.sv
// Extended Hamming (8,4) soft-decision decoder, top level. Uses h84sd_pkg, h84sd_dist.
// A codeword is searched one candidate per cycle through the shared distance unit after the
//   accept edge, a low half holding on its last candidate while a finished byte is not taken;
//   a byte shows on rsp at the edge that ends the second codeword's search. No new codeword
//   is accepted until the search ends.
// Reset (synchronous, active high): idle, next codeword is a high half, no byte pending.
`default_nettype none

module hamming84_soft_decoder_unit
   import h84sd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   // input items
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [63:0] req_tdata,   // soft_value_0 [7:0] .. soft_value_7 [63:56]
   input  wire        req_tlast,   // end_of_block
   // result items
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // decoded_byte [7:0]
   output logic       rsp_tlast    // last
);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type    state_ff,      state_in;
   sym_type      cand_ff,       cand_in;       // candidate under test
   dist_type     best_dist_ff,  best_dist_in;
   sym_type      best_sym_ff,   best_sym_in;
   soft_vec_type soft_ff,       soft_in;       // held received codeword
   logic         eob_ff,        eob_in;
   sym_type      high_ff,       high_in;       // held high nibble
   logic         second_ff,     second_in;     // next codeword is the low half
   logic         rsp_valid_ff,  rsp_valid_in;
   logic [ByteWidth-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff,   rsp_last_in;

   // ---------------------------------------------------------------------
   // Shared distance unit: one candidate per cycle
   // ---------------------------------------------------------------------
   dist_type cand_dist;

   h84sd_dist u_dist (
      .rx_soft   (soft_ff),
      .cand      (cand_ff),
      .cand_dist (cand_dist)
   );

   logic    take;       // candidate becomes the running best
   sym_type sym_final;  // winner once the last candidate is in
   logic    last_cand;
   logic    out_busy;   // output register holds a byte not yet taken

   // strict less-than keeps the lowest index on a tie
   assign take      = (cand_ff == '0) || (cand_dist < best_dist_ff);
   assign sym_final = take ? cand_ff : best_sym_ff;
   assign last_cand = (cand_ff == sym_type'(NumSymbols - 1));
   assign out_busy  = rsp_valid_ff && !rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      best_dist_in = best_dist_ff;
      best_sym_in  = best_sym_ff;
      soft_in      = soft_ff;
      eob_in       = eob_ff;
      high_in      = high_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int b = 0; b < NumBits; b++) begin
                  soft_in[b] = req_tdata[b*SoftWidth +: SoftWidth];
               end
               eob_in   = req_tlast;
               cand_in  = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (take) begin
               best_dist_in = cand_dist;
               best_sym_in  = cand_ff;
            end
            if (!last_cand) begin
               cand_in = cand_ff + 1'b1;
            end else if (!second_ff) begin
               // high half: keep the nibble, nothing to send
               high_in   = sym_final;
               second_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {high_ff, sym_final};
               rsp_last_in  = eob_ff;
               second_in    = 1'b0;
               state_in     = ST_IDLE;
            end
            // else hold on the last candidate; re-evaluating it leaves the best unchanged
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cand_ff      <= '0;
         high_ff      <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cand_ff      <= cand_in;
         high_ff      <= high_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_sym_ff  <= best_sym_in;
      soft_ff      <= soft_in;
      eob_ff       <= eob_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire
